/* src/pfce_pkg.sv */
// ----------------------------------------------------------------------------
// pfce_pkg
// Shared types, command codes and sizes of the parallel flash command engine.
// ----------------------------------------------------------------------------
package pfce_pkg;

  localparam int BANK_BYTES   = 65536;
  // power of two, at most one bank
  localparam int SECTOR_BYTES = 4096;
  localparam int ARRAY_BYTES  = 2 * BANK_BYTES;

  localparam int ADDR_W = $clog2(BANK_BYTES);
  localparam int MEM_AW = $clog2(ARRAY_BYTES);
  localparam int DATA_W = 8;
  localparam int CFG_IW = 2;

  localparam logic [ADDR_W-1:0] SECT_MASK     = ADDR_W'(SECTOR_BYTES - 1);
  localparam logic [MEM_AW-1:0] ARRAY_LAST    = MEM_AW'(ARRAY_BYTES - 1);
  localparam logic [MEM_AW-1:0] BANK_LAST     = MEM_AW'(BANK_BYTES - 1);

  localparam logic [ADDR_W-1:0] ADDR_UNLOCK_A = 16'h5555;
  localparam logic [ADDR_W-1:0] ADDR_UNLOCK_B = 16'h2AAA;
  localparam logic [ADDR_W-1:0] ADDR_BANK     = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_MAKER_ID = 16'h0000;
  localparam logic [ADDR_W-1:0] ADDR_PART_ID  = 16'h0001;

  localparam logic [DATA_W-1:0] DATA_UNLOCK_A = 8'hAA;
  localparam logic [DATA_W-1:0] DATA_UNLOCK_B = 8'h55;
  localparam logic [DATA_W-1:0] CMD_ID_ENTER  = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT   = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_ERASE     = 8'h80;
  localparam logic [DATA_W-1:0] CMD_PROGRAM   = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_BANK      = 8'hB0;
  localparam logic [DATA_W-1:0] CMD_CHIP      = 8'h10;
  localparam logic [DATA_W-1:0] CMD_SECTOR    = 8'h30;
  localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hFF;

  localparam logic [CFG_IW-1:0] CFG_LARGE_MODE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MAKER_ID   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_PART_ID    = 2'd2;

  localparam logic              LARGE_RST = 1'b1;
  localparam logic [DATA_W-1:0] MAKER_RST = 8'd98;
  localparam logic [DATA_W-1:0] PART_RST  = 8'd19;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [2:0] {
    PH_READY,
    PH_UNLOCK1,
    PH_UNLOCK2,
    PH_ERASE,
    PH_ERASE1,
    PH_ERASE2,
    PH_PROGRAM,
    PH_BANK
  } ph_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PROG,
    ACT_CHIP,
    ACT_SECTOR
  } act_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_PROG,
    ST_ERASE,
    ST_FIN
  } st_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic prog_wr;
    logic sweep_start;
    logic sweep_step;
    logic out_load;
  } pfce_cmd_t;

  typedef struct packed {
    act_e act;
    logic sweep_last;
    logic out_free;
  } pfce_stat_t;

endpackage

/* src/pfce_ctrl.sv */
// ----------------------------------------------------------------------------
// pfce_ctrl
// Sequencer: clearing pass, request intake, program and erase steps, result.
// ----------------------------------------------------------------------------
module pfce_ctrl import pfce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pfce_stat_t stat_i,
  output pfce_cmd_t  cmd_o
);

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        case (stat_i.act)
          ACT_PROG: state_d = ST_PROG;
          ACT_CHIP, ACT_SECTOR: begin
            cmd_o.sweep_start = 1'b1;
            state_d           = ST_ERASE;
          end
          default: state_d = ST_FIN;
        endcase
      end
      ST_PROG: begin
        cmd_o.prog_wr = 1'b1;
        state_d       = ST_FIN;
      end
      ST_ERASE: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* src/pfce_dp.sv */
// ----------------------------------------------------------------------------
// pfce_dp
// Datapath: command decode state, save array, erase sweep, result register.
// ----------------------------------------------------------------------------
module pfce_dp import pfce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfce_cmd_t         cmd_i,
  output pfce_stat_t        stat_o,
  input  logic              op_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;

  ph_e               phase_q;
  logic              id_mode_q;
  logic              bank_q;
  logic              large_q;
  logic [DATA_W-1:0] maker_q;
  logic [DATA_W-1:0] part_q;

  logic [MEM_AW-1:0] sweep_q;
  logic [MEM_AW-1:0] end_q;

  logic [DATA_W-1:0] mem [ARRAY_BYTES];
  logic [DATA_W-1:0] rdata_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;

  ph_e               next_ph;
  logic              id_set;
  logic              id_clr;
  logic              bank_wr;
  act_e              act;
  logic              bank_bit;
  logic [MEM_AW-1:0] loc;
  logic [DATA_W-1:0] result;

  assign bank_bit = large_q & bank_q;
  assign loc      = {bank_bit, addr_q};

  // command sequence decode
  always_comb begin
    next_ph = PH_READY;
    id_set  = 1'b0;
    id_clr  = 1'b0;
    bank_wr = 1'b0;
    act     = ACT_NONE;
    case (phase_q)
      PH_READY: begin
        if (addr_q == ADDR_UNLOCK_A && wdata_q == DATA_UNLOCK_A) next_ph = PH_UNLOCK1;
      end
      PH_UNLOCK1: begin
        if (addr_q == ADDR_UNLOCK_B && wdata_q == DATA_UNLOCK_B) next_ph = PH_UNLOCK2;
      end
      PH_UNLOCK2: begin
        if (addr_q == ADDR_UNLOCK_A) begin
          case (wdata_q)
            CMD_ID_ENTER: id_set = 1'b1;
            CMD_ID_EXIT:  id_clr = 1'b1;
            CMD_ERASE:    next_ph = PH_ERASE;
            CMD_PROGRAM:  next_ph = PH_PROGRAM;
            CMD_BANK:     if (large_q) next_ph = PH_BANK;
            default:      next_ph = PH_READY;
          endcase
        end
      end
      PH_ERASE: begin
        if (addr_q == ADDR_UNLOCK_A && wdata_q == DATA_UNLOCK_A) next_ph = PH_ERASE1;
      end
      PH_ERASE1: begin
        if (addr_q == ADDR_UNLOCK_B && wdata_q == DATA_UNLOCK_B) next_ph = PH_ERASE2;
      end
      PH_ERASE2: begin
        if (addr_q == ADDR_UNLOCK_A && wdata_q == CMD_CHIP) act = ACT_CHIP;
        else if (wdata_q == CMD_SECTOR) act = ACT_SECTOR;
      end
      PH_PROGRAM: act = ACT_PROG;
      PH_BANK: begin
        if (addr_q == ADDR_BANK) bank_wr = 1'b1;
      end
      default: next_ph = PH_READY;
    endcase
  end

  assign stat_o.act        = (op_q == OP_WRITE) ? act : ACT_NONE;
  assign stat_o.sweep_last = (sweep_q == end_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_i;
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_READY;
      id_mode_q <= 1'b0;
      bank_q    <= 1'b0;
    end else if (cmd_i.exec && op_q == OP_WRITE) begin
      phase_q <= next_ph;
      if (id_set) id_mode_q <= 1'b1;
      if (id_clr) id_mode_q <= 1'b0;
      if (bank_wr) bank_q <= wdata_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      large_q <= LARGE_RST;
      maker_q <= MAKER_RST;
      part_q  <= PART_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LARGE_MODE: large_q <= cfg_data_i[0];
        CFG_MAKER_ID:   maker_q <= cfg_data_i;
        CFG_PART_ID:    part_q  <= cfg_data_i;
        default:        large_q <= large_q;
      endcase
    end
  end

  // erase sweep pointer, starts as the clearing pass over the whole array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      end_q   <= ARRAY_LAST;
    end else if (cmd_i.sweep_start) begin
      if (act == ACT_CHIP) begin
        sweep_q <= '0;
        end_q   <= large_q ? ARRAY_LAST : BANK_LAST;
      end else begin
        sweep_q <= {bank_bit, addr_q & ~SECT_MASK};
        end_q   <= {bank_bit, addr_q | SECT_MASK};
      end
    end else if (cmd_i.sweep_step) begin
      sweep_q <= sweep_q + MEM_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step) begin
      mem[sweep_q] <= ERASED_BYTE;
    end else if (cmd_i.prog_wr) begin
      mem[loc] <= rdata_q & wdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) rdata_q <= mem[loc];
  end

  always_comb begin
    result = '0;
    if (op_q == OP_READ) begin
      if (id_mode_q && addr_q == ADDR_MAKER_ID) result = maker_q;
      else if (id_mode_q && addr_q == ADDR_PART_ID) result = part_q;
      else result = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_data_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/parallel_flash_command_engine.sv */
// ----------------------------------------------------------------------------
// parallel_flash_command_engine
// Byte-wide parallel flash save chip with unlock command sequences.
// ----------------------------------------------------------------------------
// channel   dir  contents
// s_axis    in   tuser: opcode; tdata: address, write_data
// m_axis    out  tdata: read_data
// cfg       in   large_mode, maker_id, part_id by index
//
// a read, an id write or a broken sequence passes IDLE, EXEC and FIN; program
// adds PROG; sector erase sweeps SECTOR_BYTES bytes, chip erase 64K or 128K,
// one byte per cycle through the single write port of the save array
// after reset a clearing pass over all 131072 bytes fills the array with FF;
// no request is taken until it ends
// a finished result waits in the output register while the next request
// is taken; a result stalled there holds back only the following one
// ----------------------------------------------------------------------------
module parallel_flash_command_engine import pfce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,  // address, write_data
  input  logic              s_axis_tuser,  // opcode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // read_data
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  pfce_cmd_t  cmd;
  pfce_stat_t stat;

  pfce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (s_axis_tuser),
    .addr_i      (s_axis_tdata[15:0]),
    .wdata_i     (s_axis_tdata[23:16]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_prog_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.prog_wr |-> $past(cmd.exec))
    else $error("program write without a preceding array read");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrites a pending result");
`endif

endmodule

/* verif/tb_parallel_flash_command_engine.sv */
// ----------------------------------------------------------------------------
// tb_parallel_flash_command_engine
// Self-checking bench for the parallel flash command engine. A short directed
// part walks reads, program, id mode, bank select, sector and chip erase and
// a broken unlock. Randomized unlock sequences then run under five chip
// settings. Every read result is compared against a behavioral copy of the
// command state machine and the 128KB save array, with random idle cycles on
// both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_parallel_flash_command_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import pfce_pkg::*;

  localparam int unsigned IDLE_CYCLES  = 16;
  localparam int unsigned STALL_CYCLES = 150;
  localparam int unsigned HOT_DEPTH    = 32;

  typedef struct {
    logic              opcode;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] read_data;
  } flash_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;   // address, write_data
  logic              s_axis_tuser;   // opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;   // read_data
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [DATA_W-1:0] cfg_data_i;

  // behavioral copy of the chip
  logic [DATA_W-1:0] flash_mem [ARRAY_BYTES];
  ph_e               model_phase = PH_READY;
  logic              model_bank  = 1'b0;
  logic              model_id_on = 1'b0;
  logic              cfg_large   = LARGE_RST;
  logic [DATA_W-1:0] cfg_maker   = MAKER_RST;
  logic [DATA_W-1:0] cfg_part    = PART_RST;

  flash_result_t     expected_bytes [$];
  logic [ADDR_W-1:0] hot_addrs [$];

  int unsigned request_count    = 0;
  int unsigned result_count     = 0;
  int unsigned mismatch_count   = 0;
  int unsigned sector_erases    = 0;
  int unsigned chip_erases      = 0;
  int unsigned bank_writes      = 0;
  int          erase_budget     = 250000;
  bit          gaps_on          = 1'b1;
  bit          stall_req        = 1'b0;

  parallel_flash_command_engine DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned flash_index(input int unsigned a);
    return ((cfg_large && model_bank) ? BANK_BYTES : 0) + (a % BANK_BYTES);
  endfunction

  function automatic logic [DATA_W-1:0] predict_access(input logic op,
                                                        input logic [ADDR_W-1:0] addr,
                                                        input logic [DATA_W-1:0] data);
    ph_e         next_phase;
    int unsigned base;
    int unsigned span;
    if (op == OP_READ) begin
      if (model_id_on && addr == ADDR_MAKER_ID) return cfg_maker;
      if (model_id_on && addr == ADDR_PART_ID) return cfg_part;
      return flash_mem[flash_index(addr)];
    end
    next_phase = PH_READY;
    case (model_phase)
      PH_READY: begin
        if (addr == ADDR_UNLOCK_A && data == DATA_UNLOCK_A) next_phase = PH_UNLOCK1;
      end
      PH_UNLOCK1: begin
        if (addr == ADDR_UNLOCK_B && data == DATA_UNLOCK_B) next_phase = PH_UNLOCK2;
      end
      PH_UNLOCK2: begin
        if (addr == ADDR_UNLOCK_A) begin
          if (data == CMD_ID_ENTER) model_id_on = 1'b1;
          else if (data == CMD_ID_EXIT) model_id_on = 1'b0;
          else if (data == CMD_ERASE) next_phase = PH_ERASE;
          else if (data == CMD_PROGRAM) next_phase = PH_PROGRAM;
          else if (data == CMD_BANK && cfg_large) next_phase = PH_BANK;
        end
      end
      PH_ERASE: begin
        if (addr == ADDR_UNLOCK_A && data == DATA_UNLOCK_A) next_phase = PH_ERASE1;
      end
      PH_ERASE1: begin
        if (addr == ADDR_UNLOCK_B && data == DATA_UNLOCK_B) next_phase = PH_ERASE2;
      end
      PH_ERASE2: begin
        if (addr == ADDR_UNLOCK_A && data == CMD_CHIP) begin
          span = cfg_large ? ARRAY_BYTES : BANK_BYTES;
          for (int unsigned i = 0; i < span; i++) flash_mem[i] = ERASED_BYTE;
          chip_erases++;
        end else if (data == CMD_SECTOR) begin
          base = int'(addr) - (int'(addr) % SECTOR_BYTES);
          for (int unsigned i = 0; i < SECTOR_BYTES && base + i < BANK_BYTES; i++)
            flash_mem[flash_index(base + i)] = ERASED_BYTE;
          sector_erases++;
        end
      end
      PH_PROGRAM: begin
        flash_mem[flash_index(addr)] = flash_mem[flash_index(addr)] & data;
      end
      PH_BANK: begin
        if (addr == ADDR_BANK) begin
          model_bank = data[0];
          bank_writes++;
        end
      end
      default: ;
    endcase
    model_phase = next_phase;
    return '0;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [3:0] top;
    if (hot_addrs.size() != 0 && $urandom_range(0, 1) == 0)
      return hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
    if ($urandom_range(0, 3) == 0) return ADDR_W'($urandom);
    case ($urandom_range(0, 3))
      0:       top = 4'h0;
      1:       top = 4'h2;
      2:       top = 4'h5;
      default: top = 4'hF;
    endcase
    return {top, 12'($urandom)};
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
    int unsigned   gap;
    flash_result_t item;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {data, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    item.opcode    = op;
    item.addr      = addr;
    item.read_data = predict_access(op, addr, data);
    expected_bytes.insert(expected_bytes.size(), item);
    request_count++;
  endtask

  task automatic read_byte(input logic [ADDR_W-1:0] a);
    send_request(OP_READ, a, DATA_W'($urandom));
  endtask

  task automatic unlock_cmd(input logic [DATA_W-1:0] cmd, input logic [ADDR_W-1:0] a);
    send_request(OP_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A);
    send_request(OP_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B);
    send_request(OP_WRITE, a, cmd);
  endtask

  task automatic program_byte(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    unlock_cmd(CMD_PROGRAM, ADDR_UNLOCK_A);
    send_request(OP_WRITE, a, d);
    hot_addrs.insert(hot_addrs.size(), a);
    if (hot_addrs.size() > HOT_DEPTH) void'(hot_addrs.pop_front());
  endtask

  task automatic select_bank(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    unlock_cmd(CMD_BANK, ADDR_UNLOCK_A);
    send_request(OP_WRITE, a, d);
  endtask

  task automatic erase_sector_at(input logic [ADDR_W-1:0] a);
    unlock_cmd(CMD_ERASE, ADDR_UNLOCK_A);
    unlock_cmd(CMD_SECTOR, a);
  endtask

  task automatic erase_chip();
    unlock_cmd(CMD_ERASE, ADDR_UNLOCK_A);
    unlock_cmd(CMD_CHIP, ADDR_UNLOCK_A);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_IW-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_LARGE_MODE: cfg_large = value[0];
      CFG_MAKER_ID:   cfg_maker = value;
      CFG_PART_ID:    cfg_part  = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_program();
    read_byte(16'h0000);
    read_byte(16'hFFFF);
    program_byte(16'hFFFF, 8'h5A);
    program_byte(16'hFFFF, 8'h0F);
    read_byte(16'hFFFF);
  endtask

  task automatic test_id_mode();
    unlock_cmd(CMD_ID_ENTER, ADDR_UNLOCK_A);
    read_byte(ADDR_MAKER_ID);
    read_byte(ADDR_PART_ID);
    read_byte(16'hFFFF);
    unlock_cmd(CMD_ID_EXIT, ADDR_UNLOCK_A);
    read_byte(ADDR_MAKER_ID);
  endtask

  // reads inside the unlock prefix must not disturb it
  task automatic test_bank_select();
    send_request(OP_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A);
    read_byte(16'hFFFF);
    send_request(OP_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B);
    read_byte(16'hFFFF);
    send_request(OP_WRITE, ADDR_UNLOCK_A, CMD_BANK);
    send_request(OP_WRITE, ADDR_BANK, 8'h01);
    read_byte(16'hFFFF);
    select_bank(ADDR_BANK, 8'hFE);
    read_byte(16'hFFFF);
  endtask

  task automatic test_erase();
    erase_sector_at(16'hF123);
    read_byte(16'hFFFF);
    erase_chip();
    read_byte(16'h0000);
  endtask

  task automatic test_broken_sequence();
    send_request(OP_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A);
    send_request(OP_WRITE, ADDR_UNLOCK_B ^ 16'h0001, DATA_UNLOCK_B);
    send_request(OP_WRITE, ADDR_UNLOCK_A, CMD_PROGRAM);
    send_request(OP_WRITE, 16'h0000, 8'h00);
    read_byte(16'h0000);
  endtask

  task automatic test_backpressure();
    stall_req = 1'b1;
    gaps_on   = 1'b0;
    repeat (24) read_byte(pick_addr());
    gaps_on   = 1'b1;
  endtask

  task automatic test_random_traffic(input logic large_on, input logic [DATA_W-1:0] maker,
                                     input logic [DATA_W-1:0] part,
                                     input int unsigned n_items, input bit gaps);
    int unsigned       start;
    int unsigned       pick;
    int                chip_cost;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    wait_idle();
    write_config(CFG_LARGE_MODE, {7'($urandom), large_on});
    write_config(CFG_MAKER_ID, maker);
    write_config(CFG_PART_ID, part);
    gaps_on = gaps;
    start   = request_count;
    while (request_count - start < n_items) begin
      pick      = $urandom_range(0, 99);
      chip_cost = cfg_large ? ARRAY_BYTES : BANK_BYTES;
      if (pick < 30) begin
        a = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom_range(0, 1)) : pick_addr();
        read_byte(a);
      end else if (pick < 50) begin
        program_byte(pick_addr(), DATA_W'($urandom));
      end else if (pick < 56) begin
        unlock_cmd(CMD_ID_ENTER, ADDR_UNLOCK_A);
      end else if (pick < 62) begin
        unlock_cmd(CMD_ID_EXIT, ADDR_UNLOCK_A);
      end else if (pick < 68) begin
        a = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom) : ADDR_BANK;
        select_bank(a, DATA_W'($urandom));
      end else if (pick < 73 && erase_budget >= SECTOR_BYTES) begin
        erase_budget -= SECTOR_BYTES;
        erase_sector_at(pick_addr());
      end else if (pick == 73 && erase_budget >= chip_cost) begin
        erase_budget -= chip_cost;
        erase_chip();
      end else if (pick < 86) begin
        // sequences that go wrong somewhere along the way
        case ($urandom_range(0, 3))
          0: begin
            send_request(OP_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A);
            send_request(OP_WRITE, ADDR_UNLOCK_B,
                         DATA_UNLOCK_B ^ DATA_W'($urandom_range(1, 255)));
          end
          1: begin
            a = pick_addr();
            if (a == ADDR_UNLOCK_A) a = ADDR_UNLOCK_B;
            unlock_cmd(($urandom_range(0, 1) == 0) ? CMD_PROGRAM : CMD_ERASE, a);
            send_request(OP_WRITE, pick_addr(), DATA_W'($urandom));
          end
          2: begin
            unlock_cmd(CMD_ERASE, ADDR_UNLOCK_A);
            send_request(OP_WRITE, pick_addr(), DATA_UNLOCK_A);
          end
          default: begin
            unlock_cmd(CMD_ERASE, ADDR_UNLOCK_A);
            send_request(OP_WRITE, ADDR_UNLOCK_A, DATA_UNLOCK_A);
            send_request(OP_WRITE, ADDR_UNLOCK_B, DATA_UNLOCK_B);
            a = pick_addr();
            if (a == ADDR_UNLOCK_A) a = ADDR_UNLOCK_B;
            d = DATA_W'($urandom);
            if (d == CMD_SECTOR) d = CMD_CHIP;
            send_request(OP_WRITE, a, d);
          end
        endcase
      end else if (pick < 92) begin
        a = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom) : ADDR_UNLOCK_A;
        unlock_cmd(DATA_W'($urandom), a);
      end else begin
        send_request(OP_WRITE, ADDR_W'($urandom), DATA_W'($urandom));
      end
    end
    read_byte(ADDR_MAKER_ID);
    read_byte(ADDR_PART_ID);
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    flash_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("result %02h with no request pending", m_axis_tdata));
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.read_data)
          report_mismatch($sformatf("%s at %04h: read_data %02h, want %02h",
                                    (want.opcode == OP_WRITE) ? "write" : "read",
                                    want.addr, m_axis_tdata, want.read_data));
      end
    end
  end

  // result side: random hold-off per result, one long stall on request
  initial begin
    int unsigned pause;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk_i);
        stall_req = 1'b0;
      end
      pause = gaps_on ? $urandom_range(0, 5) : 0;
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    #30ms;
    $display("timeout with %0d results outstanding", expected_bytes.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_READ;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_LARGE_MODE;
    cfg_data_i    = '0;
    foreach (flash_mem[i]) flash_mem[i] = ERASED_BYTE;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_program();
    test_id_mode();
    test_bank_select();
    test_erase();
    test_broken_sequence();
    test_backpressure();
    test_random_traffic(1'b1, 8'h00, 8'hFF, 300, 1'b1);
    test_random_traffic(1'b0, 8'hFF, 8'h00, 300, 1'b1);
    test_random_traffic(1'b1, DATA_W'($urandom), DATA_W'($urandom), 300, 1'b0);
    test_random_traffic(1'b0, DATA_W'($urandom), DATA_W'($urandom), 300, 1'b1);
    test_random_traffic(1'b1, MAKER_RST, PART_RST, 300, 1'b1);
    wait_idle();

    $display("%0d requests, %0d results over five chip settings", request_count,
             result_count);
    $display("%0d sector erases, %0d chip erases, %0d bank writes, %0d mismatches",
             sector_erases, chip_erases, bank_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
